/* src/nti_pkg.sv */
// Shared types and constants of the note tuning table interpolation core.
// Used by the sequencer top level and the constant divider; depends on nothing.
`default_nettype none

package nti_pkg;

  // Default sizes
  localparam int unsigned TABLE_ENTRIES_DEF = 128;
  localparam int unsigned FRACTION_BITS_DEF = 16;

  // Log domain: Q8.26 values, 26 square roots of two
  localparam int unsigned LOG_FRAC   = 26;
  localparam int unsigned ROOT_COUNT = 26;
  localparam int unsigned LOG_W      = 34;

  // 440 Hz in Q16.16 is 55 * 2^19
  localparam logic [31:0] A440_RAW  = 32'd28835840;
  localparam int unsigned DIV_SHIFT = 19;
  localparam logic [5:0]  DIV_ODD   = 6'd55;
  localparam int unsigned QUO_W     = 64 - DIV_SHIFT;

  // Reset table walk: log of note k is log2(440) - 23*2^24 + floor(k*2^24/3)
  localparam logic [LOG_W-1:0] FILL_OFS  = 34'd385875968;
  localparam logic [LOG_W-1:0] FILL_STEP = 34'd5592405;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_INT   = 2'd1,
    MODE_FRAC  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    JOB_FILL,
    JOB_INT,
    JOB_FRAC
  } job_e;

  typedef enum logic [1:0] {
    LT_A440,
    LT_LOW,
    LT_HIGH
  } log_tgt_e;

  typedef enum logic [4:0] {
    S_ROOT_INIT,
    S_SQRT,
    S_LOGA_INIT,
    S_LOG_NORM,
    S_LOG_SQ,
    S_LOG_UPD,
    S_EXP_MUL,
    S_EXP_UPD,
    S_PLACE,
    S_IDLE,
    S_M1_MUL,
    S_M2_RD2,
    S_M2_CHK,
    S_BL1,
    S_BL2,
    S_BL3,
    S_DT_MUL,
    S_DIV_GO,
    S_DIV_WAIT,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

/* src/nti_cdiv.sv */
// Divider by the constant 440.0 in Q16.16 (55 * 2^19): drop the power of two, then
// divide by 55 one 16-bit digit at a time by reciprocal multiplication.
// Depends on nti_pkg for the divisor split and quotient width.
`default_nettype none

module nti_cdiv import nti_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [63:0]      dividend_i,
  output logic             done_o,
  output logic [QUO_W-1:0] quotient_o
);

  // Three 16-bit digits cover the 45-bit shifted dividend
  localparam int unsigned DIG_W  = 16;
  localparam int unsigned NUM_W  = 3 * DIG_W;
  localparam int unsigned PART_W = DIG_W + 6;
  localparam int unsigned RCP_W  = 23;
  localparam int unsigned PRD_W  = PART_W + RCP_W;
  localparam int unsigned RCP_SH = 28;
  // ceil(2^28 / 55): exact for every partial dividend below 55 * 2^16
  localparam logic [RCP_W-1:0] RCP  = 23'd4880645;
  localparam logic [1:0]       LAST = 2'd2;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic              ph_q, ph_d;
  logic [1:0]        cnt_q, cnt_d;
  logic [NUM_W-1:0]  num_q, num_d;
  logic [NUM_W-1:0]  quo_q, quo_d;
  logic [5:0]        rem_q, rem_d;
  logic [PART_W-1:0] part_q, part_d;
  logic [PRD_W-1:0]  prd_q, prd_d;
  logic [PART_W-1:0] part;
  logic [DIG_W-1:0]  qdig;

  // Multiply the partial by the reciprocal, then take the digit and the remainder
  always_comb begin
    part   = {rem_q, num_q[NUM_W-1 -: DIG_W]};
    qdig   = prd_q[RCP_SH +: DIG_W];
    busy_d = busy_q;
    done_d = 1'b0;
    ph_d   = ph_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    part_d = part_q;
    prd_d  = prd_q;
    if (start_i) begin
      busy_d = 1'b1;
      ph_d   = 1'b0;
      cnt_d  = '0;
      num_d  = NUM_W'(dividend_i[63:DIV_SHIFT]);
      quo_d  = '0;
      rem_d  = '0;
    end else if (busy_q) begin
      if (!ph_q) begin
        part_d = part;
        prd_d  = PRD_W'(part) * PRD_W'(RCP);
        num_d  = num_q << DIG_W;
        ph_d   = 1'b1;
      end else begin
        quo_d = {quo_q[NUM_W-DIG_W-1:0], qdig};
        rem_d = 6'(part_q - PART_W'(qdig) * PART_W'(DIV_ODD));
        ph_d  = 1'b0;
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == LAST) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ph_q   <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      ph_q   <= ph_d;
      cnt_q  <= cnt_d;
    end
  end

  // Advance the datapath
  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    part_q <= part_d;
    prd_q  <= prd_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q[QUO_W-1:0];

endmodule

`default_nettype wire

/* src/note_tuning_table_interp_core.sv */
// Note tuning table core: table memory, sequencer and shared 32x32 multiplier.
// Depends on nti_pkg and instantiates nti_cdiv.
//
// Usage: requests enter on in_valid_i/in_ready_o with mode_i, note_index_i,
// note_fraction_i and freq_value_i; results leave on out_valid_o/out_ready_i.
// The master tune register is written by cfg_we_i/cfg_wdata_i at any edge.
// Mode 0 writes one in-range entry in the accepting cycle and gives no result; mode 3
// is dropped. Mode 1 scales an entry by master tune / 440: a table read, one
// multiply and the divide by 440. Mode 2 runs two log2 passes (up to 31 normalising
// shifts plus 26 squarings each), a blend, a 26-step exp2 and the divider on one
// shared multiplier, skipping the second pass for a zero upper entry. Out-of-range
// lookups return 440 Hz. One request is in flight at a time; in_ready_o is high
// only while idle. After reset the sequencer computes the root table and fills
// the note table with equal-tempered values, during which no request is taken.
// A finished result waits in the output register while the receiver stalls;
// the core accepts the next request as soon as it has moved the result there.
`default_nettype none

module note_tuning_table_interp_core import nti_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [6:0]  note_index_i,
  input  logic [15:0] note_fraction_i,
  input  logic [31:0] freq_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] frequency_o,
  output logic        used_fallback_o
);

  localparam int unsigned AW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned FB  = FRACTION_BITS;
  localparam int unsigned BLW = FB + 32;
  localparam logic [10:0]   TE_W     = 11'(TABLE_ENTRIES);
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);
  localparam logic [4:0]    LOG_LAST = 5'(LOG_FRAC - 1);
  localparam logic [4:0]    ROOT_LAST = 5'(ROOT_COUNT - 1);
  localparam logic [FB:0]   W_ONE    = (FB + 1)'(1) << FB;

  // Sequencer and datapath registers
  state_e          st_q, st_d;
  job_e            job_q, job_d;
  log_tgt_e        tgt_q, tgt_d;
  logic [31:0]     mt_q;
  logic [6:0]      idx_q, idx_d;
  logic [FB-1:0]   t_q, t_d;
  logic [31:0]     f2_q, f2_d;
  logic [31:0]     m_q, m_d;
  logic [4:0]      e_q, e_d;
  logic [25:0]     frac_q, frac_d;
  logic [4:0]      cnt_q, cnt_d;
  logic [30:0]     l1_q, l1_d;
  logic [30:0]     l2_q, l2_d;
  logic [LOG_W-1:0] lg_q, lg_d;
  logic [31:0]     acc_q, acc_d;
  logic [BLW-1:0]  blend_q, blend_d;
  logic [QUO_W-1:0] q_q, q_d;
  logic [30:0]     roots_q [ROOT_COUNT];
  logic            root_we;
  logic [4:0]      rk_q, rk_d;
  logic [62:0]     sv_q, sv_d;
  logic [62:0]     sr_q, sr_d;
  logic [62:0]     sb_q, sb_d;
  logic [AW-1:0]   k_q, k_d;
  logic [1:0]      r3_q, r3_d;
  logic [31:0]     res_q, res_d;
  logic            rfb_q, rfb_d;
  logic            out_valid_q, out_valid_d;
  logic [31:0]     freq_q;
  logic            fb_q;
  logic            out_load;

  // Memory ports and shared multiplier
  logic [31:0]     mem [TABLE_ENTRIES];
  logic            wr_en, rd_en;
  logic [AW-1:0]   wr_addr, rd_addr;
  logic [31:0]     wr_data;
  logic [31:0]     rdata_q;
  logic [31:0]     mul_a, mul_b;
  logic [63:0]     prod_q;

  // Divider
  logic             div_start;
  logic             div_done;
  logic [QUO_W-1:0] div_quo;

  // Helpers
  logic [10:0]     idx_in_ext, idx_q_p1;
  logic [23:0]     frac_in_ext;
  logic [32:0]     sq;
  logic [30:0]     lv;
  logic [62:0]     sq_trial;
  logic [62:0]     sr_next;
  logic [25:0]     lfrac;
  logic [BLW-1:0]  blend_sum;
  logic [31:0]     acc_next;
  logic [31:0]     place_v;

  assign idx_in_ext  = {4'b0, note_index_i};
  assign idx_q_p1    = {4'b0, idx_q} + 11'd1;
  assign frac_in_ext = {8'b0, note_fraction_i};
  assign sq          = prod_q[63:31];
  assign lv          = {e_q, frac_q[24:0], sq[32]};
  assign sq_trial    = sr_q + sb_q;
  assign lfrac       = lg_q[LOG_FRAC-1:0];
  assign blend_sum   = blend_q + prod_q[BLW-1:0];
  assign acc_next    = lfrac[LOG_LAST - cnt_q] ? prod_q[61:30] : acc_q;

  // Place the exp2 result: times 2^n, round half up, saturate
  always_comb begin
    logic [7:0]  n;
    logic [54:0] up;
    logic [45:0] dn;
    logic [3:0]  sh;
    logic [4:0]  sr1;
    n       = lg_q[LOG_W-1:LOG_FRAC];
    sh      = 4'(n - 8'd30);
    sr1     = 5'(8'd29 - n);
    up      = 55'(q_q) << sh;
    dn      = (46'(q_q >> sr1) + 46'd1) >> 1;
    place_v = '0;
    if (q_q == '0) begin
      place_v = '0;
    end else if (n > 8'd40) begin
      place_v = '1;
    end else if (n >= 8'd30) begin
      place_v = (up[54:32] != '0) ? '1 : up[31:0];
    end else begin
      place_v = (dn[45:32] != '0) ? '1 : dn[31:0];
    end
  end

  // Sequencer: next state and datapath control
  always_comb begin
    st_d        = st_q;
    job_d       = job_q;
    tgt_d       = tgt_q;
    idx_d       = idx_q;
    t_d         = t_q;
    f2_d        = f2_q;
    m_d         = m_q;
    e_d         = e_q;
    frac_d      = frac_q;
    cnt_d       = cnt_q;
    l1_d        = l1_q;
    l2_d        = l2_q;
    lg_d        = lg_q;
    acc_d       = acc_q;
    blend_d     = blend_q;
    q_d         = q_q;
    rk_d        = rk_q;
    sv_d        = sv_q;
    sr_d        = sr_q;
    sb_d        = sb_q;
    k_d         = k_q;
    r3_d        = r3_q;
    res_d       = res_q;
    rfb_d       = rfb_q;
    root_we     = 1'b0;
    sr_next     = sr_q >> 1;
    wr_en       = 1'b0;
    wr_addr     = k_q;
    wr_data     = place_v;
    rd_en       = 1'b0;
    rd_addr     = idx_in_ext[AW-1:0];
    mul_a       = '0;
    mul_b       = '0;
    div_start   = 1'b0;
    out_load    = 1'b0;
    in_ready_o  = 1'b0;

    unique case (st_q)
      // Square-root chain for the roots of two
      S_ROOT_INIT: begin
        sv_d  = (rk_q == '0) ? (63'd1 << 61) : {sr_q[32:0], 30'b0};
        sr_d  = '0;
        sb_d  = 63'd1 << 62;
        cnt_d = '0;
        st_d  = S_SQRT;
      end
      S_SQRT: begin
        if (sv_q >= sq_trial) begin
          sv_d    = sv_q - sq_trial;
          sr_next = (sr_q >> 1) + sb_q;
        end
        sr_d  = sr_next;
        sb_d  = sb_q >> 2;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          root_we = 1'b1;
          if (rk_q == ROOT_LAST) begin
            st_d = S_LOGA_INIT;
          end else begin
            rk_d = rk_q + 5'd1;
            st_d = S_ROOT_INIT;
          end
        end
      end
      S_LOGA_INIT: begin
        job_d  = JOB_FILL;
        tgt_d  = LT_A440;
        m_d    = A440_RAW;
        e_d    = 5'd31;
        frac_d = '0;
        st_d   = S_LOG_NORM;
      end
      // log2: find the top bit, then square the mantissa once per bit
      S_LOG_NORM: begin
        if (m_q[31]) begin
          cnt_d = '0;
          st_d  = S_LOG_SQ;
        end else begin
          m_d = {m_q[30:0], 1'b0};
          e_d = e_q - 5'd1;
        end
      end
      S_LOG_SQ: begin
        mul_a = m_q;
        mul_b = m_q;
        st_d  = S_LOG_UPD;
      end
      S_LOG_UPD: begin
        m_d    = sq[32] ? sq[32:1] : sq[31:0];
        frac_d = {frac_q[24:0], sq[32]};
        cnt_d  = cnt_q + 5'd1;
        st_d   = S_LOG_SQ;
        if (cnt_q == LOG_LAST) begin
          unique case (tgt_q)
            LT_A440: begin
              lg_d  = LOG_W'(lv) - FILL_OFS;
              k_d   = '0;
              r3_d  = '0;
              acc_d = 32'd1 << 30;
              cnt_d = '0;
              st_d  = S_EXP_MUL;
            end
            LT_LOW: begin
              l1_d = lv;
              if (f2_q == '0) begin
                l2_d = '0;
                st_d = S_BL1;
              end else begin
                m_d    = f2_q;
                e_d    = 5'd31;
                frac_d = '0;
                tgt_d  = LT_HIGH;
                st_d   = S_LOG_NORM;
              end
            end
            default: begin
              l2_d = lv;
              st_d = S_BL1;
            end
          endcase
        end
      end
      // exp2 of the fraction: product of the selected roots
      S_EXP_MUL: begin
        mul_a = acc_q;
        mul_b = {1'b0, roots_q[cnt_q]};
        st_d  = S_EXP_UPD;
      end
      S_EXP_UPD: begin
        acc_d = acc_next;
        cnt_d = cnt_q + 5'd1;
        st_d  = S_EXP_MUL;
        if (cnt_q == LOG_LAST) begin
          if (job_q == JOB_FILL) begin
            q_d  = QUO_W'(acc_next);
            st_d = S_PLACE;
          end else begin
            st_d = S_DT_MUL;
          end
        end
      end
      S_PLACE: begin
        rfb_d = 1'b0;
        unique case (job_q)
          JOB_INT: begin
            res_d = (q_q[QUO_W-1:32] != '0) ? '1 : q_q[31:0];
            st_d  = S_DONE;
          end
          JOB_FRAC: begin
            res_d = place_v;
            st_d  = S_DONE;
          end
          default: begin
            wr_en = 1'b1;
            if (k_q == LAST_IDX) begin
              st_d = S_IDLE;
            end else begin
              k_d   = k_q + AW'(1);
              lg_d  = lg_q + FILL_STEP + ((r3_q == 2'd2) ? LOG_W'(1) : LOG_W'(0));
              r3_d  = (r3_q == 2'd2) ? 2'd0 : r3_q + 2'd1;
              acc_d = 32'd1 << 30;
              cnt_d = '0;
              st_d  = S_EXP_MUL;
            end
          end
        endcase
      end
      // Take a request and decode it
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          idx_d = note_index_i;
          t_d   = frac_in_ext[FB-1:0];
          unique case (mode_e'(mode_i))
            MODE_WRITE: begin
              wr_en   = (idx_in_ext < TE_W);
              wr_addr = idx_in_ext[AW-1:0];
              wr_data = freq_value_i;
            end
            MODE_INT: begin
              job_d = JOB_INT;
              if (idx_in_ext < TE_W) begin
                rd_en = 1'b1;
                st_d  = S_M1_MUL;
              end else begin
                res_d = A440_RAW;
                rfb_d = 1'b1;
                st_d  = S_DONE;
              end
            end
            MODE_FRAC: begin
              job_d = JOB_FRAC;
              if ((idx_in_ext + 11'd1) >= TE_W) begin
                res_d = A440_RAW;
                rfb_d = 1'b1;
                st_d  = S_DONE;
              end else begin
                rd_en = 1'b1;
                st_d  = S_M2_RD2;
              end
            end
            default: begin
              st_d = S_IDLE;
            end
          endcase
        end
      end
      S_M1_MUL: begin
        mul_a = rdata_q;
        mul_b = mt_q;
        st_d  = S_DIV_GO;
      end
      S_M2_RD2: begin
        m_d     = rdata_q;
        e_d     = 5'd31;
        frac_d  = '0;
        rd_en   = 1'b1;
        rd_addr = idx_q_p1[AW-1:0];
        st_d    = S_M2_CHK;
      end
      S_M2_CHK: begin
        f2_d = rdata_q;
        if (m_q == '0 || (rdata_q == '0 && t_q != '0)) begin
          res_d = '0;
          rfb_d = 1'b0;
          st_d  = S_DONE;
        end else begin
          tgt_d = LT_LOW;
          st_d  = S_LOG_NORM;
        end
      end
      // Linear blend of the two logs
      S_BL1: begin
        mul_a = {1'b0, l1_q};
        mul_b = 32'(W_ONE - {1'b0, t_q});
        st_d  = S_BL2;
      end
      S_BL2: begin
        blend_d = prod_q[BLW-1:0];
        mul_a   = {1'b0, l2_q};
        mul_b   = 32'(t_q);
        st_d    = S_BL3;
      end
      S_BL3: begin
        lg_d  = LOG_W'(blend_sum >> FB);
        acc_d = 32'd1 << 30;
        cnt_d = '0;
        st_d  = S_EXP_MUL;
      end
      S_DT_MUL: begin
        mul_a = acc_q;
        mul_b = mt_q;
        st_d  = S_DIV_GO;
      end
      S_DIV_GO: begin
        div_start = 1'b1;
        st_d      = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          q_d  = div_quo;
          st_d = S_PLACE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          st_d     = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load | (out_valid_q & ~out_ready_i);

  // Hold control state and the master tune register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_ROOT_INIT;
      job_q       <= JOB_FILL;
      tgt_q       <= LT_A440;
      cnt_q       <= '0;
      rk_q        <= '0;
      k_q         <= '0;
      r3_q        <= '0;
      out_valid_q <= 1'b0;
      mt_q        <= A440_RAW;
    end else begin
      st_q        <= st_d;
      job_q       <= job_d;
      tgt_q       <= tgt_d;
      cnt_q       <= cnt_d;
      rk_q        <= rk_d;
      k_q         <= k_d;
      r3_q        <= r3_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        mt_q <= cfg_wdata_i;
      end
    end
  end

  // Advance the datapath registers
  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    t_q     <= t_d;
    f2_q    <= f2_d;
    m_q     <= m_d;
    e_q     <= e_d;
    frac_q  <= frac_d;
    l1_q    <= l1_d;
    l2_q    <= l2_d;
    lg_q    <= lg_d;
    acc_q   <= acc_d;
    blend_q <= blend_d;
    q_q     <= q_d;
    sv_q    <= sv_d;
    sr_q    <= sr_d;
    sb_q    <= sb_d;
    res_q   <= res_d;
    rfb_q   <= rfb_d;
    prod_q  <= mul_a * mul_b;
    if (root_we) begin
      roots_q[rk_q] <= sr_next[30:0];
    end
    if (out_load) begin
      freq_q <= res_q;
      fb_q   <= rfb_q;
    end
  end

  // Note table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  nti_cdiv u_cdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign out_valid_o     = out_valid_q;
  assign frequency_o     = freq_q;
  assign used_fallback_o = fb_q;

endmodule

`default_nettype wire
